@@ design/mdt_pkg.sv @@
// Package for the monitor deadline timer: item types, state type, codes and helpers.
package mdt_pkg;

    localparam int TIME_W = 64;
    localparam int SPAN_W = 32;
    localparam int SEQ_W  = 16;
    localparam int WAIT_W = 31;
    localparam int OP_W   = 3;
    localparam int CFG_IDX_W = 2;

    localparam logic [TIME_W-1:0] TIME_ALL_ONES = {TIME_W{1'b1}};
    localparam logic [WAIT_W-1:0] WAIT_MAX      = {WAIT_W{1'b1}};

    localparam logic [SPAN_W-1:0] PING_PERIOD_RST = SPAN_W'(1000);
    localparam logic [SPAN_W-1:0] WDOG_PERIOD_RST = '0;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_START         = 3'd0;
    localparam logic [OP_W-1:0] OP_PING_ARM      = 3'd1;
    localparam logic [OP_W-1:0] OP_PING_CLEAR    = 3'd2;
    localparam logic [OP_W-1:0] OP_SHUTDOWN_ARM  = 3'd3;
    localparam logic [OP_W-1:0] OP_SHUTDOWN_CLR  = 3'd4;
    localparam logic [OP_W-1:0] OP_ADVANCE       = 3'd5;
    localparam logic [OP_W-1:0] OP_WDOG_SENT     = 3'd6;
    localparam logic [OP_W-1:0] OP_QUERY         = 3'd7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PING_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WDOG_PERIOD = 2'd1;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [TIME_W-1:0] now_ms;
        logic [SPAN_W-1:0] reply_timeout_ms;
        logic [SEQ_W-1:0]  expected_seq;
        logic [SPAN_W-1:0] shutdown_delay_ms;
    } t_in_item;

    typedef struct packed {
        logic              op_ok;
        logic              ping_waiting;
        logic              ping_expired;
        logic [TIME_W-1:0] ping_sent_at_ms;
        logic [SEQ_W-1:0]  awaited_seq;
        logic              shutdown_pending;
        logic              shutdown_expired;
        logic              ping_due;
        logic              watchdog_due;
        logic [WAIT_W-1:0] wait_ms;
    } t_out_item;

    typedef struct packed {
        logic              reply_pending;
        logic [TIME_W-1:0] reply_sent_time;
        logic [TIME_W-1:0] reply_deadline;
        logic [SEQ_W-1:0]  reply_seq;
        logic              shutdown_armed;
        logic [TIME_W-1:0] shutdown_deadline;
        logic [TIME_W-1:0] next_ping_time;
        logic [TIME_W-1:0] watchdog_last_time;
    } t_state;

    typedef struct packed {
        logic [SPAN_W-1:0] ping_period_ms;
        logic [SPAN_W-1:0] watchdog_period_ms;
    } t_cfg;

    typedef struct packed {
        logic              ok;
        logic [TIME_W-1:0] sum;
    } t_sum;

    // A sum is usable only if it neither wraps nor lands on all ones.
    function automatic t_sum sum_chk(input logic [TIME_W-1:0] a,
                                     input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        t_sum            r;
        s     = {1'b0, a} + {1'b0, b};
        r.sum = s[TIME_W-1:0];
        r.ok  = !s[TIME_W] && (s[TIME_W-1:0] != TIME_ALL_ONES);
        return r;
    endfunction

    // Time left until a deadline, clamped to the range of the wait field.
    function automatic logic [WAIT_W-1:0] until_ms(input logic [TIME_W-1:0] now,
                                                   input logic [TIME_W-1:0] deadline);
        logic [TIME_W-1:0] d;
        logic [WAIT_W-1:0] r;
        d = deadline - now;
        if (deadline <= now) begin
            r = '0;
        end else if (d[TIME_W-1:WAIT_W] != '0) begin
            r = WAIT_MAX;
        end else begin
            r = d[WAIT_W-1:0];
        end
        return r;
    endfunction

endpackage

@@ design/monitor_deadline_timer.sv @@
// Top level of the monitor deadline timer: handshakes, state and config registers.
//
//   Channel   Direction  Handshake                  Payload
//   in        to block   i_in_valid / o_in_stall    i_in_item   (t_in_item)
//   out       from block o_out_valid / i_out_stall  o_out_item  (t_out_item)
//   cfg       to block   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Each accepted event is held in the input register, then the update and
// report logic fill the result register from it.
// The block sustains one event per cycle; the result register and the
// input register form a two-stage pipeline that only stops when the output
// side stalls while a result is waiting. Reset is synchronous and active
// low; it clears all timer state and loads the configuration reset values.
// A stall on the output side propagates to o_in_stall in the same cycle
// only when both the input and the result register are occupied.
module monitor_deadline_timer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  mdt_pkg::t_in_item        i_in_item,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output mdt_pkg::t_out_item       o_out_item,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [1:0]               i_cfg_index,
    input  logic [31:0]              i_cfg_data
);
    import mdt_pkg::*;

    logic      r_in_vld;
    logic      n_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;
    t_state    r_st;
    t_state    n_st;
    t_cfg      r_cfg;
    t_out_item n_out;
    logic      upd_ok;
    logic      out_free;
    logic      fire;
    logic      in_acc;

    // The result register can take a new transaction when it is empty or
    // its current one is leaving this cycle.
    assign out_free    = !r_out_vld || !i_out_stall;
    assign fire        = r_in_vld && out_free;
    assign o_in_stall  = r_in_vld && !out_free;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    always_comb begin
        n_in_vld = r_in_vld;
        if (in_acc) begin
            n_in_vld = 1'b1;
        end else if (fire) begin
            n_in_vld = 1'b0;
        end
    end

    mdt_update u_update (
        .i_item  (r_in),
        .i_state (r_st),
        .i_cfg   (r_cfg),
        .o_state (n_st),
        .o_ok    (upd_ok)
    );

    // Results are reported against the state after this event's update.
    mdt_report u_report (
        .i_state  (n_st),
        .i_cfg    (r_cfg),
        .i_now_ms (r_in.now_ms),
        .i_ok     (upd_ok),
        .o_item   (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_st      <= '0;
            r_cfg.ping_period_ms     <= PING_PERIOD_RST;
            r_cfg.watchdog_period_ms <= WDOG_PERIOD_RST;
        end else begin
            r_in_vld <= n_in_vld;
            if (fire) begin
                r_out_vld <= 1'b1;
                r_st      <= n_st;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
            // Writes to indexes beyond the register list are dropped.
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PING_PERIOD: r_cfg.ping_period_ms     <= i_cfg_data;
                    CFG_WDOG_PERIOD: r_cfg.watchdog_period_ms <= i_cfg_data;
                    default: begin
                        r_cfg <= r_cfg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in <= i_in_item;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && (r_in.operation == OP_START)) |=>
        (!r_st.reply_pending && !r_st.shutdown_armed &&
         (r_st.next_ping_time == r_st.watchdog_last_time)))
        else $error("start did not clear the timer state");

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_vld)
        else $error("processed transaction did not reach the result register");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled without a blocked result");

    a_expired_needs_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((!r_out.shutdown_expired || r_out.shutdown_pending) &&
                       (!r_out.ping_expired || r_out.ping_waiting)))
        else $error("expired flag reported without an armed deadline");

endmodule

@@ design/mdt_update.sv @@
// Next-state logic of the deadline timer for one event.
module mdt_update (
    input  mdt_pkg::t_in_item i_item,
    input  mdt_pkg::t_state   i_state,
    input  mdt_pkg::t_cfg     i_cfg,
    output mdt_pkg::t_state   o_state,
    output logic              o_ok
);
    import mdt_pkg::*;

    t_sum sum_tmo;
    t_sum sum_delay;
    t_sum sum_sched;
    t_sum sum_now;

    assign sum_tmo   = sum_chk(i_item.now_ms, TIME_W'(i_item.reply_timeout_ms));
    assign sum_delay = sum_chk(i_item.now_ms, TIME_W'(i_item.shutdown_delay_ms));
    assign sum_sched = sum_chk(i_state.next_ping_time, TIME_W'(i_cfg.ping_period_ms));
    assign sum_now   = sum_chk(i_item.now_ms, TIME_W'(i_cfg.ping_period_ms));

    always_comb begin
        o_state = i_state;
        o_ok    = 1'b1;
        case (i_item.operation)
            OP_START: begin
                o_state                    = '0;
                o_state.next_ping_time     = i_item.now_ms;
                o_state.watchdog_last_time = i_item.now_ms;
            end
            OP_PING_ARM: begin
                if (sum_tmo.ok) begin
                    o_state.reply_pending   = 1'b1;
                    o_state.reply_sent_time = i_item.now_ms;
                    o_state.reply_deadline  = sum_tmo.sum;
                    o_state.reply_seq       = i_item.expected_seq;
                end else begin
                    o_ok = 1'b0;
                end
            end
            OP_PING_CLEAR: begin
                o_state.reply_pending   = 1'b0;
                o_state.reply_sent_time = '0;
                o_state.reply_deadline  = '0;
                o_state.reply_seq       = '0;
            end
            OP_SHUTDOWN_ARM: begin
                if (sum_delay.ok) begin
                    o_state.shutdown_armed    = 1'b1;
                    o_state.shutdown_deadline = sum_delay.sum;
                end else begin
                    o_ok = 1'b0;
                end
            end
            OP_SHUTDOWN_CLR: begin
                o_state.shutdown_armed    = 1'b0;
                o_state.shutdown_deadline = '0;
            end
            OP_ADVANCE: begin
                // Catch up to now plus the period when the schedule fell behind.
                if (sum_sched.ok && (sum_sched.sum >= i_item.now_ms)) begin
                    o_state.next_ping_time = sum_sched.sum;
                end else if (sum_now.ok) begin
                    o_state.next_ping_time = sum_now.sum;
                end else begin
                    o_ok = 1'b0;
                end
            end
            OP_WDOG_SENT: begin
                o_state.watchdog_last_time = i_item.now_ms;
            end
            OP_QUERY: begin
                o_state = i_state;
            end
            default: begin
                o_state = i_state;
            end
        endcase
    end

endmodule

@@ design/mdt_report.sv @@
// Result item built from the updated state: flags and the clamped wait.
module mdt_report (
    input  mdt_pkg::t_state       i_state,
    input  mdt_pkg::t_cfg         i_cfg,
    input  logic [63:0]           i_now_ms,
    input  logic                  i_ok,
    output mdt_pkg::t_out_item    o_item
);
    import mdt_pkg::*;

    logic [TIME_W-1:0] base_time;
    logic [WAIT_W-1:0] wait_base;
    logic [WAIT_W-1:0] wait_shut;
    logic [WAIT_W-1:0] wait_wdog;
    logic [WAIT_W-1:0] wait_min;
    logic              wdog_on;
    t_sum              wdog_sum;

    assign wdog_on   = (i_cfg.watchdog_period_ms != '0);
    assign wdog_sum  = sum_chk(i_state.watchdog_last_time,
                               TIME_W'(i_cfg.watchdog_period_ms));
    assign base_time = i_state.reply_pending ? i_state.reply_deadline
                                             : i_state.next_ping_time;
    assign wait_base = until_ms(i_now_ms, base_time);
    assign wait_shut = until_ms(i_now_ms, i_state.shutdown_deadline);
    assign wait_wdog = wdog_sum.ok ? until_ms(i_now_ms, wdog_sum.sum) : WAIT_MAX;

    always_comb begin
        wait_min = wait_base;
        if (i_state.shutdown_armed && (wait_shut < wait_min)) begin
            wait_min = wait_shut;
        end
        if (wdog_on && (wait_wdog < wait_min)) begin
            wait_min = wait_wdog;
        end
    end

    always_comb begin
        o_item.op_ok            = i_ok;
        o_item.ping_waiting     = i_state.reply_pending;
        o_item.ping_expired     = i_state.reply_pending &&
                                  (i_now_ms >= i_state.reply_deadline);
        o_item.ping_sent_at_ms  = i_state.reply_sent_time;
        o_item.awaited_seq      = i_state.reply_seq;
        o_item.shutdown_pending = i_state.shutdown_armed;
        o_item.shutdown_expired = i_state.shutdown_armed &&
                                  (i_now_ms >= i_state.shutdown_deadline);
        o_item.ping_due         = (i_now_ms >= i_state.next_ping_time);
        o_item.watchdog_due     = wdog_on &&
                                  ((i_now_ms - i_state.watchdog_last_time) >=
                                   TIME_W'(i_cfg.watchdog_period_ms));
        o_item.wait_ms          = wait_min;
    end

endmodule
